FILE: sv/bgnc_pkg.sv
// ----------------------------------------------------------------------------
// Binary grid neighbor count package
// Shared constants for the neighbor count unit and its checker.
// ----------------------------------------------------------------------------
package bgnc_pkg;

	localparam int MAX_SIZE_DEF = 64;

	localparam int GRID_SIZE_W = 7;
	localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_GRID_SIZE = 0;

	localparam int CELL_W = 3;
	localparam logic [CELL_W-1:0] CELL_MAX = 3'd4;
	localparam logic [CELL_W-1:0] CELL_SET = 3'd1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

endpackage

FILE: sv/binary_grid_neighbor_count_unit.sv
// ----------------------------------------------------------------------------
// Binary grid neighbor count unit
// Counts the set edge neighbors of each clear pixel of a square binary image; a set pixel gives 1.
// ----------------------------------------------------------------------------
// The host writes grid_size over the APB port while the unit is idle; a write
// starts a new frame. Pixels then enter in raster order on the input channel
// (operation = pixel), one word per cycle while in_stall is low. The result
// for a cell of row r-1 is produced when the pixel of row r in the same
// column is accepted, so the first row gives no results. After the last
// pixel the host sends one drain word per column to flush the final row;
// the last drain word carries frame_end. Pixel words past the last row and
// drain words before it are dropped without a result.
// The unit takes one word per cycle while in_stall is low. Each result is
// registered on the output channel in an output register backed by one
// skid entry, so the input keeps flowing while a result waits. Two
// row-long shift lines with a tap point set by grid_size hold the previous
// two rows. in_stall rises only when both the output register and the skid
// entry are full, and falls once the receiver takes a word. Reset empties
// the output side, clears the frame counters and sets grid_size to 8.
// ----------------------------------------------------------------------------
module binary_grid_neighbor_count_unit #(
	parameter int MAX_SIZE = bgnc_pkg::MAX_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bgnc_pkg::PADDR_W-1:0]     paddr,
	input  logic [bgnc_pkg::PDATA_W-1:0]     pwdata,
	output logic [bgnc_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic                             pixel_bit,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bgnc_pkg::CELL_W-1:0]      cell_value,
	output logic                             row_end,
	output logic                             frame_end
);

	localparam int CW = $clog2(MAX_SIZE);
	localparam int RW = $clog2(MAX_SIZE + 1);
	localparam int SW = (RW > bgnc_pkg::GRID_SIZE_W) ? RW : bgnc_pkg::GRID_SIZE_W;
	localparam int AW = bgnc_pkg::PADDR_W - 2;

	logic [bgnc_pkg::GRID_SIZE_W-1:0] grid_size_q;
	logic [SW-1:0] gs_ext;
	logic [RW-1:0] n;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [CW:0]   col_inc;
	logic          cfg_wr;
	logic          reg_sel;

	logic line_a_q [MAX_SIZE];
	logic line_b_q [MAX_SIZE];
	logic line_a_d [MAX_SIZE];
	logic line_b_d [MAX_SIZE];
	logic prev_q;

	logic accept, is_pix, pix_ok, drain_ok, shift, has_res, last_col;
	logic a_in;
	logic up, left, right, below;
	logic [bgnc_pkg::CELL_W-1:0] value;

	logic                        out_valid_q, skid_valid_q;
	logic [bgnc_pkg::CELL_W-1:0] out_cell_q, skid_cell_q;
	logic                        out_row_q, out_frame_q, skid_row_q, skid_frame_q;
	logic                        out_fire;

	assign pready  = 1'b1;
	assign reg_sel = paddr[bgnc_pkg::PADDR_W-1:2] == AW'(bgnc_pkg::REG_GRID_SIZE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? bgnc_pkg::PDATA_W'(grid_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= bgnc_pkg::GRID_SIZE_RST;
		end else if (cfg_wr) begin
			grid_size_q <= pwdata[bgnc_pkg::GRID_SIZE_W-1:0];
		end
	end

	assign gs_ext = SW'(grid_size_q);

	always_comb begin
		if (gs_ext == '0) begin
			n = RW'(1);
		end else if (gs_ext > SW'(MAX_SIZE)) begin
			n = RW'(MAX_SIZE);
		end else begin
			n = RW'(gs_ext);
		end
	end

	assign accept   = in_valid && !in_stall;
	assign is_pix   = operation == bgnc_pkg::OP_PIXEL;
	assign pix_ok   = is_pix && (row_q < n);
	assign drain_ok = (operation == bgnc_pkg::OP_DRAIN) && (row_q == n);
	assign shift    = accept && (pix_ok || drain_ok);
	assign has_res  = shift && (drain_ok || row_q != '0);
	assign col_inc  = (CW + 1)'(col_q) + (CW + 1)'(1);
	assign last_col = col_inc == (CW + 1)'(n);
	assign a_in     = pix_ok && pixel_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (shift) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= drain_ok ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	for (genvar i = 0; i < MAX_SIZE; i++) begin : g_line
		if (i == MAX_SIZE - 1) begin : g_tail
			assign line_a_d[i] = (RW'(i + 1) == n) ? a_in : line_a_q[i];
			assign line_b_d[i] = (RW'(i + 1) == n) ? line_a_q[0] : line_b_q[i];
		end else begin : g_body
			assign line_a_d[i] = (RW'(i + 1) == n) ? a_in : line_a_q[i + 1];
			assign line_b_d[i] = (RW'(i + 1) == n) ? line_a_q[0] : line_b_q[i + 1];
		end

		always_ff @(posedge clk) begin
			if (shift) begin
				line_a_q[i] <= line_a_d[i];
				line_b_q[i] <= line_b_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			prev_q <= line_a_q[0];
		end
	end

	assign up    = line_b_q[0] && (row_q >= RW'(2));
	assign left  = prev_q && (col_q != '0);
	assign right = line_a_q[1] && !last_col;
	assign below = pix_ok && pixel_bit;

	always_comb begin
		if (line_a_q[0]) begin
			value = bgnc_pkg::CELL_SET;
		end else begin
			value = bgnc_pkg::CELL_W'(up) + bgnc_pkg::CELL_W'(left)
				+ bgnc_pkg::CELL_W'(right) + bgnc_pkg::CELL_W'(below);
		end
	end

	assign out_fire = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (has_res) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_cell_q  <= skid_cell_q;
				out_row_q   <= skid_row_q;
				out_frame_q <= skid_frame_q;
			end
		end else if (has_res) begin
			if (out_valid_q && !out_fire) begin
				skid_cell_q  <= value;
				skid_row_q   <= last_col;
				skid_frame_q <= last_col && drain_ok;
			end else begin
				out_cell_q  <= value;
				out_row_q   <= last_col;
				out_frame_q <= last_col && drain_ok;
			end
		end
	end

	assign in_stall   = skid_valid_q;
	assign out_valid  = out_valid_q;
	assign cell_value = out_cell_q;
	assign row_end    = out_row_q;
	assign frame_end  = out_frame_q;

endmodule

FILE: sv/bgnc_checker.sv
// ----------------------------------------------------------------------------
// Binary grid neighbor count checker
// Port-level properties of the neighbor count unit, bound to its top level.
// ----------------------------------------------------------------------------
module bgnc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [bgnc_pkg::CELL_W-1:0]  cell_value,
	input logic                         row_end,
	input logic                         frame_end
);

	a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_value <= bgnc_pkg::CELL_MAX)
		else $error("cell_value above four");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_value)
			&& $stable(row_end) && $stable(frame_end))
		else $error("stalled result word changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a blocked output");

endmodule

bind binary_grid_neighbor_count_unit bgnc_checker u_bgnc_checker (.*);

FILE: dv/bgnc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary grid neighbor count checker
// Watches the APB port and both word channels of the neighbor count unit.
// It keeps its own copy of grid_size, the frame counters and the last two
// rows of pixels, predicts the result of every accepted input word that has
// one and compares each accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module bgnc_tb_checker #(
	parameter int MAX_SIZE = bgnc_pkg::MAX_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bgnc_pkg::PADDR_W-1:0] paddr,
	input  logic [bgnc_pkg::PDATA_W-1:0] pwdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         operation,
	input  logic                         pixel_bit,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [bgnc_pkg::CELL_W-1:0]  cell_value,
	input  logic                         row_end,
	input  logic                         frame_end,
	output int                           fail_count,
	output int                           pending
);

	localparam logic [bgnc_pkg::PADDR_W-1:0] GRID_SIZE_ADDR =
		bgnc_pkg::PADDR_W'(bgnc_pkg::REG_GRID_SIZE * 4);

	typedef struct packed {
		logic [bgnc_pkg::CELL_W-1:0] cell_val;
		logic                        last_in_row;
		logic                        last_in_frame;
	} cell_word_t;

	cell_word_t                       cells_due[$];
	logic [bgnc_pkg::GRID_SIZE_W-1:0] size_reg;
	logic                             history [2][MAX_SIZE];
	int unsigned                      row_idx;
	int unsigned                      col_idx;

	function automatic int unsigned active_side();
		if (size_reg == '0) return 1;
		if (int'(size_reg) > MAX_SIZE) return MAX_SIZE;
		return int'(size_reg);
	endfunction

	function automatic logic [bgnc_pkg::CELL_W-1:0] cell_at(int unsigned r, int unsigned c,
		int unsigned n, logic below);
		int unsigned mid;
		int unsigned sum;
		mid = r - 1;
		if (history[mid % 2][c]) return bgnc_pkg::CELL_SET;
		sum = below;
		if (mid >= 1) sum += history[(mid - 1) % 2][c];
		if (c >= 1) sum += history[mid % 2][c - 1];
		if (c + 1 < n) sum += history[mid % 2][c + 1];
		return bgnc_pkg::CELL_W'(sum);
	endfunction

	task automatic predict_word(input logic op, input logic pix);
		int unsigned n;
		int unsigned r;
		int unsigned c;
		cell_word_t  res;
		n = active_side();
		r = row_idx;
		c = col_idx;
		if (c >= n) c = 0;
		if (op == bgnc_pkg::OP_PIXEL) begin
			if (r < n) begin
				if (r >= 1) begin
					res.cell_val = cell_at(r, c, n, pix);
					res.last_in_row = (c + 1 == n);
					res.last_in_frame = 1'b0;
					cells_due.push_back(res);
				end
				history[r % 2][c] = pix;
				if (c + 1 == n) begin
					col_idx = 0;
					row_idx = r + 1;
				end else begin
					col_idx = c + 1;
				end
			end
		end else if (r == n) begin
			res.cell_val = cell_at(r, c, n, 1'b0);
			res.last_in_row = (c + 1 == n);
			res.last_in_frame = res.last_in_row;
			cells_due.push_back(res);
			if (c + 1 == n) begin
				col_idx = 0;
				row_idx = 0;
			end else begin
				col_idx = c + 1;
			end
		end
	endtask

	task automatic compare_word();
		cell_word_t exp_word;
		if (cells_due.size() == 0) begin
			$error("result word with no prediction waiting: cell_value %0d", cell_value);
			fail_count++;
			return;
		end
		exp_word = cells_due.pop_front();
		if (cell_value !== exp_word.cell_val) begin
			$error("cell_value mismatch: expected %0d, actual %0d", exp_word.cell_val,
				cell_value);
			fail_count++;
		end
		if (row_end !== exp_word.last_in_row) begin
			$error("row_end mismatch: expected %0d, actual %0d", exp_word.last_in_row, row_end);
			fail_count++;
		end
		if (frame_end !== exp_word.last_in_frame) begin
			$error("frame_end mismatch: expected %0d, actual %0d",
				exp_word.last_in_frame, frame_end);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = bgnc_pkg::GRID_SIZE_RST;
			row_idx = 0;
			col_idx = 0;
			fail_count = 0;
			foreach (history[i, j]) history[i][j] = 1'b0;
			cells_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == GRID_SIZE_ADDR) begin
				size_reg = pwdata[bgnc_pkg::GRID_SIZE_W-1:0];
				row_idx = 0;
				col_idx = 0;
			end
			if (in_valid && !in_stall) predict_word(operation, pixel_bit);
			if (out_valid && !out_stall) compare_word();
		end
		pending = cells_due.size();
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary grid neighbor count testbench
// Drives the neighbor count unit with directed frames covering the special
// cases, a back-pressure stretch and random frames of many sizes, with random
// gaps on both channels. A checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [bgnc_pkg::PADDR_W-1:0] GRID_SIZE_ADDR =
		bgnc_pkg::PADDR_W'(bgnc_pkg::REG_GRID_SIZE * 4);
	localparam logic [bgnc_pkg::PADDR_W-1:0] UNMAPPED_ADDR = bgnc_pkg::PADDR_W'(4);
	localparam int RANDOM_ITEMS = 1550;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT = 20000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [bgnc_pkg::PADDR_W-1:0] paddr = '0;
	logic [bgnc_pkg::PDATA_W-1:0] pwdata = '0;
	logic [bgnc_pkg::PDATA_W-1:0] prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         operation = bgnc_pkg::OP_PIXEL;
	logic                         pixel_bit = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [bgnc_pkg::CELL_W-1:0]  cell_value;
	logic                         row_end;
	logic                         frame_end;
	logic                         hold_req = 1'b0;
	logic                         hold_taken = 1'b0;

	int fail_count;
	int pending;
	int tx_idle_pct = 27;
	int rx_idle_pct = 48;
	int random_items = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	binary_grid_neighbor_count_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .pixel_bit(pixel_bit),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_value(cell_value), .row_end(row_end), .frame_end(frame_end)
	);

	bgnc_tb_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .pixel_bit(pixel_bit),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_value(cell_value), .row_end(row_end), .frame_end(frame_end),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic send_word(input logic op, input logic pix);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel_bit <= pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic apb_write(input logic [bgnc_pkg::PADDR_W-1:0] addr,
		input logic [bgnc_pkg::PDATA_W-1:0] data);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned n, input bit complete);
		int unsigned ones_pct;
		int unsigned total;
		int unsigned k;
		ones_pct = $urandom_range(0, 100);
		total = complete ? n * n : 2 * n + $urandom_range(0, n);
		for (k = 0; k < total; k++) begin
			if ($urandom_range(0, 99) < 3) begin
				send_word(bgnc_pkg::OP_DRAIN, 1'($urandom_range(0, 1)));
			end
			send_word(bgnc_pkg::OP_PIXEL, $urandom_range(0, 99) < ones_pct);
			random_items++;
		end
		if (!complete) return;
		if ($urandom_range(0, 99) < 20) send_word(bgnc_pkg::OP_PIXEL, 1'($urandom_range(0, 1)));
		for (k = 0; k < n; k++) begin
			send_word(bgnc_pkg::OP_DRAIN, 1'($urandom_range(0, 1)));
			random_items++;
		end
	endtask

	initial begin
		int unsigned k;
		int unsigned pick;
		int unsigned side;
		int unsigned frames;
		logic [bgnc_pkg::GRID_SIZE_W-1:0] size_val;
		int guard;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size of eight: an early drain word is dropped, row 0 gives nothing.
		send_word(bgnc_pkg::OP_DRAIN, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);

		// A size of zero acts as one; a pixel past the last row is dropped.
		apb_write(GRID_SIZE_ADDR, 32'd0);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_DRAIN, 1'b0);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_DRAIN, 1'b1);

		apb_write(GRID_SIZE_ADDR, 32'hFFFF_FF82);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_DRAIN, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);
		send_word(bgnc_pkg::OP_DRAIN, 1'b0);
		send_word(bgnc_pkg::OP_DRAIN, 1'b1);

		// A write outside the register map leaves the size and the frame alone.
		apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b1);
		send_word(bgnc_pkg::OP_PIXEL, 1'b0);
		send_word(bgnc_pkg::OP_DRAIN, 1'b0);
		send_word(bgnc_pkg::OP_DRAIN, 1'b1);

		// The receiver holds off long enough to fill the unit, and later the
		// sender waits for every outstanding result in the middle of a frame.
		apb_write(GRID_SIZE_ADDR, 32'd4);
		for (k = 0; k < 16; k++) begin
			if (k == 4) hold_req <= 1'b1;
			if (k == 12) wait_for_results();
			send_word(bgnc_pkg::OP_PIXEL, 1'($urandom_range(0, 1)));
		end
		for (k = 0; k < 4; k++) send_word(bgnc_pkg::OP_DRAIN, 1'($urandom_range(0, 1)));

		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (random_items >= RANDOM_ITEMS / 3) begin
				tx_idle_pct = 48;
				rx_idle_pct = 27;
			end
			pick = $urandom_range(0, 99);
			if (pick < 6) size_val = '0;
			else if (pick < 10) size_val = 7'd1;
			else if (pick < 15) size_val = 7'd64;
			else if (pick < 18) size_val = 7'd127;
			else if (pick < 21) size_val = bgnc_pkg::GRID_SIZE_W'($urandom_range(65, 126));
			else if (pick < 33) size_val = bgnc_pkg::GRID_SIZE_W'($urandom_range(7, 16));
			else size_val = bgnc_pkg::GRID_SIZE_W'($urandom_range(2, 6));
			side = (size_val == '0) ? 1
				: (int'(size_val) > bgnc_pkg::MAX_SIZE_DEF) ? bgnc_pkg::MAX_SIZE_DEF
				: int'(size_val);
			apb_write(GRID_SIZE_ADDR, {25'($urandom()), size_val});
			frames = (side <= 16) ? $urandom_range(1, 3) : 1;
			repeat (frames) send_frame(side, side <= 16);
		end

		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending != 0 && guard < DRAIN_LIMIT);
		repeat (20) @(posedge clk);
		if (pending != 0) $error("%0d predicted results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
sv/bgnc_pkg.sv
sv/binary_grid_neighbor_count_unit.sv
sv/bgnc_checker.sv
dv/bgnc_checker.sv
dv/tb.sv
